// ===== src/tep_pkg.sv =====
// tile entry packer: shared types, format and register codes, header byte table
// no dependencies; used by every other file of the block but tep_checker.sv
package tep_pkg;

   localparam int TILE_ID_W  = 11;
   localparam int PAL_W      = 5;
   localparam int DIM_W      = 11;
   localparam int FMT_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam int HDR_LEN   = 36;
   localparam int POS_W     = 6;
   localparam int CMD_SLOTS = 5;
   localparam int SLOT_W    = $clog2(CMD_SLOTS + 1);

   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = Q_AW + 1;

   localparam logic [FMT_W-1:0] FMT_PLAIN       = 4'd0;
   localparam logic [FMT_W-1:0] FMT_ATTR9       = 4'd1;
   localparam logic [FMT_W-1:0] FMT_4BPP        = 4'd2;
   localparam logic [FMT_W-1:0] FMT_8BPP        = 4'd3;
   localparam logic [FMT_W-1:0] FMT_4BPP_HDR    = 4'd4;
   localparam logic [FMT_W-1:0] FMT_8BPP_HDR    = 4'd5;
   localparam logic [FMT_W-1:0] FMT_BORDER      = 4'd6;
   localparam logic [FMT_W-1:0] FMT_ATTR10      = 4'd7;
   localparam logic [FMT_W-1:0] FMT_ATTR_FIRST  = 4'd8;
   localparam logic [FMT_W-1:0] FMT_ID_PAL      = 4'd9;
   localparam logic [FMT_W-1:0] FMT_RLE_NIBBLE  = 4'd10;
   localparam logic [FMT_W-1:0] FMT_PLAIN_END_A = 4'd11;
   localparam logic [FMT_W-1:0] FMT_PLAIN_END_B = 4'd12;
   localparam logic [FMT_W-1:0] FMT_RLE_PAIR_00 = 4'd13;
   localparam logic [FMT_W-1:0] FMT_RLE_PAIR_FF = 4'd14;

   localparam logic [CSR_IDX_W-1:0] CSR_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [DIM_W-1:0] DIM_RESET = 11'd32;

   localparam logic [7:0] RUN_LIMIT_NIBBLE = 8'h0F;
   localparam logic [7:0] RUN_LIMIT_PAIR   = 8'hFF;
   localparam logic [7:0] END_MARK_FF      = 8'hFF;
   localparam logic [7:0] END_MARK_00      = 8'h00;
   localparam logic [7:0] BORDER_ATTR      = 8'h10;

   localparam logic [23:0] FILE_EXTRA     = 24'h24;
   localparam logic [23:0] DATA_EXTRA     = 24'h14;
   localparam logic [7:0]  HDR_CHUNK_SIZE = 8'h10;

   typedef logic [SLOT_W-1:0]          slot_cnt_type;
   typedef logic [CMD_SLOTS-1:0][7:0]  slot_bytes_type;

   // one queued work item for the back end
   typedef struct packed {
      logic           hdr;
      logic           last;
      slot_cnt_type   cnt;
      slot_bytes_type bytes;
   } cmd_type;

   typedef struct packed {
      logic [DIM_W-1:0] width_tiles;
      logic [DIM_W-1:0] height_tiles;
      logic [23:0]      map_size;
      logic [23:0]      total_size;
      logic [23:0]      data_size;
   } cfg_type;

   function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] idx, input cfg_type c);
      logic [15:0] w8;
      logic [15:0] h8;
      logic [7:0]  b;
      w8 = {2'b00, c.width_tiles, 3'b000};
      h8 = {2'b00, c.height_tiles, 3'b000};
      unique case (idx)
         6'd0:  b = 8'h52;
         6'd1:  b = 8'h43;
         6'd2:  b = 8'h53;
         6'd3:  b = 8'h4E;
         6'd4:  b = 8'hFF;
         6'd5:  b = 8'hFE;
         6'd7:  b = 8'h01;
         6'd8:  b = c.total_size[7:0];
         6'd9:  b = c.total_size[15:8];
         6'd10: b = c.total_size[23:16];
         6'd12: b = HDR_CHUNK_SIZE;
         6'd14: b = 8'h01;
         6'd16: b = 8'h4E;
         6'd17: b = 8'h52;
         6'd18: b = 8'h43;
         6'd19: b = 8'h53;
         6'd20: b = c.data_size[7:0];
         6'd21: b = c.data_size[15:8];
         6'd22: b = c.data_size[23:16];
         6'd24: b = w8[7:0];
         6'd25: b = w8[15:8];
         6'd26: b = h8[7:0];
         6'd27: b = h8[15:8];
         6'd32: b = c.map_size[7:0];
         6'd33: b = c.map_size[15:8];
         6'd34: b = c.map_size[23:16];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== src/tep_ifs.sv =====
// tile entry packer: request and response channel interfaces
// depends on tep_pkg for field widths
interface tep_req_if;
   import tep_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [TILE_ID_W-1:0]        tile_id;
   logic                        flip_x;
   logic                        flip_y;
   logic                        prio;
   logic                        obj_palette_one;
   logic signed [PAL_W-1:0]     pal_index;
   logic                        last_tile;

   modport source (output valid, tile_id, flip_x, flip_y, prio, obj_palette_one, pal_index,
                   last_tile, input ready);
   modport sink   (input valid, tile_id, flip_x, flip_y, prio, obj_palette_one, pal_index,
                   last_tile, output ready);
   modport monitor (input valid, ready, tile_id, flip_x, flip_y, prio, obj_palette_one,
                    pal_index, last_tile);
endinterface

interface tep_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;

   modport source  (output valid, out_byte, last_byte, input ready);
   modport sink    (input valid, out_byte, last_byte, output ready);
   modport monitor (input valid, ready, out_byte, last_byte);
endinterface

// ===== src/tep_front.sv =====
// tile entry packer front end: config registers, run state, per-tile byte list
// depends on tep_pkg and tep_ifs
module tep_front (
   input  logic                           clock,
   input  logic                           reset,
   tep_req_if.sink                        req_ch,
   input  logic                           csr_we,
   input  logic [tep_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tep_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           push_valid,
   output tep_pkg::cmd_type               push_cmd,
   input  logic                           push_ready,
   output tep_pkg::cfg_type               cfg
);
   import tep_pkg::*;

   logic [FMT_W-1:0] format_ff;
   logic [DIM_W-1:0] width_ff;
   logic [DIM_W-1:0] height_ff;
   logic [21:0]      prod_ff;
   logic [23:0]      total_size_ff;
   logic [23:0]      data_size_ff;
   logic [23:0]      map_size;

   logic [7:0] rv_ff, rv_in;
   logic [7:0] rc_ff, rc_in;
   logic       hs_ff, hs_in;

   logic             acc;
   logic [3:0]       pal;
   logic [7:0]       lo;
   logic [7:0]       limit;
   logic             nibble;
   logic             cont;
   logic             close_old;
   logic             flush;
   logic [7:0]       rc1;
   logic [7:0]       rv1;
   logic [7:0]       attr;
   slot_cnt_type     n;
   slot_bytes_type   bytes;
   cmd_type          cmd;

   function automatic slot_bytes_type put_byte(input slot_bytes_type arr,
                                               input slot_cnt_type pos,
                                               input logic [7:0] b);
      slot_bytes_type r;
      r = arr;
      if (int'(pos) < CMD_SLOTS) begin
         r[pos] = b;
      end
      return r;
   endfunction

   assign map_size = {1'b0, prod_ff, 1'b0};
   assign cfg = '{width_tiles: width_ff, height_tiles: height_ff, map_size: map_size,
                  total_size: total_size_ff, data_size: data_size_ff};

   assign req_ch.ready = push_ready && !reset;
   assign acc          = req_ch.valid && req_ch.ready;
   assign push_valid   = acc && (cmd.cnt != '0);
   assign push_cmd     = cmd;

   always_comb begin
      pal    = req_ch.pal_index[PAL_W-1] ? 4'h0 : req_ch.pal_index[3:0];
      lo     = req_ch.tile_id[7:0];
      nibble = (format_ff == FMT_RLE_NIBBLE);
      limit  = nibble ? RUN_LIMIT_NIBBLE : RUN_LIMIT_PAIR;
      cont      = (rc_ff != 8'd0) && (rv_ff == lo);
      close_old = (rc_ff != 8'd0) && !cont;
      rc1       = cont ? rc_ff + 8'd1 : 8'd1;
      rv1       = cont ? rv_ff : lo;
      flush     = (rc1 >= limit) || req_ch.last_tile;
      attr  = 8'h00;
      bytes = '0;
      n     = '0;
      hs_in = hs_ff;
      rv_in = rv_ff;
      rc_in = rc_ff;
      cmd   = '0;

      unique case (format_ff) inside
         FMT_PLAIN, FMT_PLAIN_END_A, FMT_PLAIN_END_B: begin
            bytes[0] = lo | {req_ch.flip_y, req_ch.flip_x, 6'b000000};
            n = slot_cnt_type'(1);
            if (req_ch.last_tile && format_ff != FMT_PLAIN) begin
               bytes[1] = END_MARK_FF;
               n = slot_cnt_type'(2);
            end
         end
         FMT_ATTR9: begin
            attr = {req_ch.prio, req_ch.flip_y, req_ch.flip_x, req_ch.obj_palette_one,
                    req_ch.tile_id[8], pal[2:0]};
            bytes[0] = lo;
            bytes[1] = attr;
            n = slot_cnt_type'(2);
         end
         FMT_4BPP, FMT_8BPP, FMT_4BPP_HDR, FMT_8BPP_HDR: begin
            attr = {pal, req_ch.flip_y, req_ch.flip_x, req_ch.tile_id[9:8]};
            bytes[0] = lo;
            bytes[1] = attr;
            n = slot_cnt_type'(2);
            if ((format_ff == FMT_4BPP_HDR || format_ff == FMT_8BPP_HDR) && !hs_ff) begin
               cmd.hdr = 1'b1;
               hs_in   = 1'b1;
            end
         end
         FMT_BORDER: begin
            attr = BORDER_ATTR | {req_ch.flip_y, req_ch.flip_x, 2'b00, pal[1:0], 2'b00};
            bytes[0] = lo;
            bytes[1] = attr;
            n = slot_cnt_type'(2);
         end
         FMT_ATTR10: begin
            attr = {req_ch.flip_y, req_ch.flip_x, req_ch.prio, pal[2:0],
                    req_ch.tile_id[9:8]};
            bytes[0] = lo;
            bytes[1] = attr;
            n = slot_cnt_type'(2);
         end
         FMT_ATTR_FIRST: begin
            attr = {req_ch.prio, pal[1:0], req_ch.flip_y, req_ch.flip_x,
                    req_ch.tile_id[10:8]};
            bytes[0] = attr;
            bytes[1] = lo;
            n = slot_cnt_type'(2);
         end
         FMT_ID_PAL: begin
            attr = {pal, 1'b0, req_ch.tile_id[10:8]};
            bytes[0] = lo;
            bytes[1] = attr;
            n = slot_cnt_type'(2);
         end
         FMT_RLE_NIBBLE, FMT_RLE_PAIR_00, FMT_RLE_PAIR_FF: begin
            if (close_old) begin
               if (nibble) begin
                  bytes = put_byte(bytes, n, {rv_ff[3:0], rc_ff[3:0]});
                  n = n + slot_cnt_type'(1);
               end else begin
                  bytes = put_byte(bytes, n, rv_ff);
                  n = n + slot_cnt_type'(1);
                  bytes = put_byte(bytes, n, rc_ff);
                  n = n + slot_cnt_type'(1);
               end
            end
            if (flush) begin
               if (nibble) begin
                  bytes = put_byte(bytes, n, {rv1[3:0], rc1[3:0]});
                  n = n + slot_cnt_type'(1);
               end else begin
                  bytes = put_byte(bytes, n, rv1);
                  n = n + slot_cnt_type'(1);
                  bytes = put_byte(bytes, n, rc1);
                  n = n + slot_cnt_type'(1);
               end
            end
            if (req_ch.last_tile) begin
               bytes = put_byte(bytes, n,
                                (format_ff == FMT_RLE_PAIR_FF) ? END_MARK_FF : END_MARK_00);
               n = n + slot_cnt_type'(1);
            end
            rv_in = rv1;
            rc_in = flush ? 8'd0 : rc1;
         end
         default: begin
            rc_in = 8'd0;
         end
      endcase

      if (req_ch.last_tile) begin
         hs_in = 1'b0;
         rc_in = 8'd0;
         rv_in = 8'd0;
      end

      cmd.last  = req_ch.last_tile;
      cmd.cnt   = n;
      cmd.bytes = bytes;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_PLAIN;
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         rv_ff     <= 8'd0;
         rc_ff     <= 8'd0;
         hs_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FORMAT: begin
               format_ff <= csr_wdata[FMT_W-1:0];
               rv_ff     <= 8'd0;
               rc_ff     <= 8'd0;
               hs_ff     <= 1'b0;
            end
            CSR_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end else if (acc) begin
         rv_ff <= rv_in;
         rc_ff <= rc_in;
         hs_ff <= hs_in;
      end
   end

   // header sizes, two register stages behind the dimension registers
   always_ff @(posedge clock) begin
      prod_ff       <= width_ff * height_ff;
      total_size_ff <= map_size + FILE_EXTRA;
      data_size_ff  <= map_size + DATA_EXTRA;
   end

endmodule

// ===== src/tep_queue.sv =====
// tile entry packer: short command queue between front and back end
// depends on tep_pkg
module tep_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  tep_pkg::cmd_type push_cmd,
   output logic             push_ready,
   output logic             pop_valid,
   output tep_pkg::cmd_type pop_cmd,
   input  logic             pop_ready
);
   import tep_pkg::*;

   cmd_type         mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ff, wr_in;
   logic [Q_AW-1:0] rd_ff, rd_in;
   logic [Q_CW-1:0] cnt_ff, cnt_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (cnt_ff != Q_CW'(Q_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_cmd    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = do_push ? wr_ff + Q_AW'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + Q_AW'(1) : rd_ff;
      cnt_in = cnt_ff + Q_CW'(do_push) - Q_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== src/tep_back.sv =====
// tile entry packer back end: header and byte sequencer with output register
// depends on tep_pkg and tep_ifs
module tep_back (
   input  logic             clock,
   input  logic             reset,
   input  tep_pkg::cfg_type cfg,
   input  logic             pop_valid,
   input  tep_pkg::cmd_type pop_cmd,
   output logic             pop_ready,
   tep_rsp_if.source        rsp_ch
);
   import tep_pkg::*;

   cmd_type            cur_ff, cur_in;
   logic               busy_ff, busy_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;

   logic               can_emit;
   logic               emit;
   logic               done;
   logic               pop;
   logic [POS_W-1:0]   last_pos;
   logic [SLOT_W-1:0]  data_idx;
   logic [7:0]         byte_now;

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_byte  = out_byte_ff;
   assign rsp_ch.last_byte = out_last_ff;

   always_comb begin
      can_emit  = !out_valid_ff || rsp_ch.ready;
      emit      = busy_ff && can_emit;
      last_pos  = POS_W'(HDR_LEN) + POS_W'(cur_ff.cnt) - POS_W'(1);
      done      = emit && (pos_ff == last_pos);
      pop_ready = !busy_ff || done;
      pop       = pop_valid && pop_ready;
      data_idx  = SLOT_W'(pos_ff - POS_W'(HDR_LEN));
      byte_now  = (pos_ff < POS_W'(HDR_LEN)) ? hdr_byte(pos_ff, cfg) : cur_ff.bytes[data_idx];

      cur_in  = pop ? pop_cmd : cur_ff;
      busy_in = pop ? 1'b1 : (done ? 1'b0 : busy_ff);
      if (pop) begin
         pos_in = pop_cmd.hdr ? '0 : POS_W'(HDR_LEN);
      end else if (emit) begin
         pos_in = pos_ff + POS_W'(1);
      end else begin
         pos_in = pos_ff;
      end

      out_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
      out_byte_in  = emit ? byte_now : out_byte_ff;
      out_last_in  = emit ? (done && cur_ff.last) : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      pos_ff      <= pos_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ===== src/tilemap_entry_packer_rle.sv =====
// tile entry packer top level: front end, command queue, back end
// depends on tep_pkg, tep_ifs, tep_front, tep_queue, tep_back
//
// One tile entry goes in per req transaction and the bytes of the selected map format come
// out one per rsp transaction, last_byte marking the final byte of the map. The response
// register moves one byte per cycle while rsp ready stays high, so the one-byte plain
// formats sustain one tile per cycle; the header formats add the 36 header bytes in
// front of the first tile of each map, and a run-length tile emits the bytes it closes.
// From an empty block, an item's first byte passes the queue entry, the current item
// register and the output register. Config writes (csr_index 0 format, 1 width, 2 height)
// are for the user to make only while no transaction is in flight; the block does not
// enforce this. Header sizes follow width and height via prod_ff and the size registers.
module tilemap_entry_packer_rle (
   input  logic                           clock,
   input  logic                           reset,
   tep_req_if.sink                        req_ch,
   tep_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [tep_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tep_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tep_pkg::*;

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    push_valid;
   logic    push_ready;
   logic    pop_valid;
   logic    pop_ready;

   tep_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .cfg        (cfg)
   );

   tep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   tep_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== src/tep_checker.sv =====
// tile entry packer port checker and its bind to the top level
// depends on the handshake and payload ports of tilemap_entry_packer_rle
module tep_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_last_byte
);

   logic seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         seen_ff <= 1'b1;
      end
   end

   // nothing comes out right after reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // no byte without an accepted tile since reset
   a_no_rsp_without_req: assert property (@(posedge clock) disable iff (reset)
      !seen_ff |-> !rsp_valid)
      else $error("response with no accepted transaction");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_byte))
      else $error("stalled response changed");

endmodule

bind tilemap_entry_packer_rle tep_checker u_tep_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_byte  (rsp_ch.out_byte),
   .rsp_last_byte (rsp_ch.last_byte)
);

// ===== tb/tilemap_entry_packer_rle_test.sv =====
`timescale 1ns / 1ps

// testbench for tilemap_entry_packer_rle: sends tile entries under random idling on both
// channels, predicts the byte stream of every format and checks each rsp transaction in order
// depends on tep_pkg, tep_ifs and tilemap_entry_packer_rle
module tilemap_entry_packer_rle_test;
   import tep_pkg::*;

   localparam logic [FMT_W-1:0] FMT_UNUSED = 4'd15;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int MAX_REPORTS   = 40;

   typedef struct packed {
      logic [TILE_ID_W-1:0] id;
      logic                 fx;
      logic                 fy;
      logic                 pr;
      logic                 ob;
      logic [PAL_W-1:0]     pal;
      logic                 last;
   } tile_entry_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } map_byte_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tep_req_if req_if();
   tep_rsp_if rsp_if();

   tilemap_entry_packer_rle uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // predicted block state
   logic [FMT_W-1:0] cur_format  = FMT_PLAIN;
   logic [DIM_W-1:0] cur_width   = DIM_RESET;
   logic [DIM_W-1:0] cur_height  = DIM_RESET;
   logic [7:0]       run_byte    = 8'h00;
   logic [7:0]       run_len     = 8'h00;
   bit               header_done = 1'b0;

   map_byte_type expected_bytes[$];
   logic [7:0]   tile_bytes[$];

   int error_count     = 0;
   int tiles_sent      = 0;
   int maps_closed     = 0;
   int bytes_checked   = 0;
   int cycle_count     = 0;
   int sender_gap_odds = 3;
   bit quiet           = 1'b0;

   function automatic void add_tile_byte(logic [7:0] b);
      tile_bytes = {tile_bytes, b};
   endfunction

   function automatic void emit_header();
      logic [31:0] n2;
      logic [31:0] fsz;
      logic [31:0] dsz;
      logic [15:0] w8;
      logic [15:0] h8;
      logic [7:0]  hdr [36];
      n2  = {21'b0, cur_width} * {21'b0, cur_height};
      n2  = n2 << 1;
      fsz = n2 + 32'h24;
      dsz = n2 + 32'h14;
      w8  = {2'b00, cur_width, 3'b000};
      h8  = {2'b00, cur_height, 3'b000};
      hdr = '{8'h52, 8'h43, 8'h53, 8'h4E, 8'hFF, 8'hFE, 8'h00, 8'h01,
              fsz[7:0], fsz[15:8], fsz[23:16], fsz[31:24],
              8'h10, 8'h00, 8'h01, 8'h00,
              8'h4E, 8'h52, 8'h43, 8'h53,
              dsz[7:0], dsz[15:8], dsz[23:16], dsz[31:24],
              w8[7:0], w8[15:8], h8[7:0], h8[15:8],
              8'h00, 8'h00, 8'h00, 8'h00,
              n2[7:0], n2[15:8], n2[23:16], n2[31:24]};
      foreach (hdr[i]) add_tile_byte(hdr[i]);
   endfunction

   function automatic void emit_run();
      if (cur_format == FMT_RLE_NIBBLE) begin
         add_tile_byte({run_byte[3:0], run_len[3:0]});
      end else begin
         add_tile_byte(run_byte);
         add_tile_byte(run_len);
      end
   endfunction

   // bytes that one accepted tile entry produces, appended to expected_bytes
   function automatic void predict_tile(tile_entry_type t);
      logic [7:0]   lo;
      logic [7:0]   limit;
      logic [3:0]   pal;
      map_byte_type mb;
      lo  = t.id[7:0];
      pal = t.pal[PAL_W-1] ? 4'd0 : t.pal[3:0];
      tile_bytes.delete();
      case (cur_format) inside
         FMT_PLAIN, FMT_PLAIN_END_A, FMT_PLAIN_END_B: begin
            add_tile_byte(lo | {t.fy, t.fx, 6'b000000});
            if (t.last && cur_format != FMT_PLAIN) add_tile_byte(END_MARK_FF);
         end
         FMT_ATTR9: begin
            add_tile_byte(lo);
            add_tile_byte({t.pr, t.fy, t.fx, t.ob, t.id[8], pal[2:0]});
         end
         FMT_4BPP, FMT_8BPP, FMT_4BPP_HDR, FMT_8BPP_HDR: begin
            if ((cur_format == FMT_4BPP_HDR || cur_format == FMT_8BPP_HDR) && !header_done) begin
               emit_header();
               header_done = 1'b1;
            end
            add_tile_byte(lo);
            add_tile_byte({pal, t.fy, t.fx, t.id[9:8]});
         end
         FMT_BORDER: begin
            add_tile_byte(lo);
            add_tile_byte({t.fy, t.fx, 2'b01, pal[1:0], 2'b00});
         end
         FMT_ATTR10: begin
            add_tile_byte(lo);
            add_tile_byte({t.fy, t.fx, t.pr, pal[2:0], t.id[9:8]});
         end
         FMT_ATTR_FIRST: begin
            add_tile_byte({t.pr, pal[1:0], t.fy, t.fx, t.id[10:8]});
            add_tile_byte(lo);
         end
         FMT_ID_PAL: begin
            add_tile_byte(lo);
            add_tile_byte({pal, 1'b0, t.id[10:8]});
         end
         FMT_RLE_NIBBLE, FMT_RLE_PAIR_00, FMT_RLE_PAIR_FF: begin
            limit = (cur_format == FMT_RLE_NIBBLE) ? RUN_LIMIT_NIBBLE : RUN_LIMIT_PAIR;
            if (run_len != 8'd0 && run_byte == lo) begin
               run_len = run_len + 8'd1;
            end else begin
               if (run_len != 8'd0) emit_run();
               run_byte = lo;
               run_len  = 8'd1;
            end
            if (run_len >= limit) begin
               emit_run();
               run_len = 8'd0;
            end
            if (t.last) begin
               if (run_len != 8'd0) emit_run();
               run_len = 8'd0;
               add_tile_byte((cur_format == FMT_RLE_PAIR_FF) ? END_MARK_FF : END_MARK_00);
            end
         end
         default: begin
            run_len = 8'd0;
         end
      endcase
      if (t.last) begin
         header_done = 1'b0;
         run_len     = 8'd0;
         run_byte    = 8'd0;
      end
      foreach (tile_bytes[i]) begin
         mb.data        = tile_bytes[i];
         mb.is_last     = t.last && (i == tile_bytes.size() - 1);
         expected_bytes = {expected_bytes, mb};
      end
   endfunction

   task automatic report_mismatch(string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // response checker
   always @(posedge clock) begin
      map_byte_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h last %b", rsp_if.out_byte,
                                      rsp_if.last_byte));
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_if.out_byte !== want.data)
               report_mismatch($sformatf("byte %0d: out_byte %h, want %h", bytes_checked,
                                         rsp_if.out_byte, want.data));
            if (rsp_if.last_byte !== want.is_last)
               report_mismatch($sformatf("byte %0d: last_byte %b, want %b", bytes_checked,
                                         rsp_if.last_byte, want.is_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bytes still pending", cycle_count,
                  expected_bytes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // rsp ready with random stall bursts
   initial begin
      rsp_if.ready = 1'b1;
      @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
            if ($urandom_range(0, 1) == 1) begin
               rsp_if.ready <= 1'b0;
               repeat ($urandom_range(1, 17)) @(posedge clock);
            end
         end
      end
   end

   function automatic tile_entry_type make_tile(logic [TILE_ID_W-1:0] id, logic fx, logic fy,
                                                logic pr, logic ob, logic [PAL_W-1:0] pal,
                                                logic last);
      tile_entry_type t;
      t.id = id;  t.fx = fx;  t.fy = fy;  t.pr = pr;  t.ob = ob;
      t.pal = pal;  t.last = last;
      return t;
   endfunction

   function automatic tile_entry_type random_tile(logic [TILE_ID_W-1:0] id, logic last);
      return make_tile(id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       PAL_W'($urandom_range(0, 31)), last);
   endfunction

   function automatic logic [DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 5))
         0:       return 11'd0;
         1:       return 11'd1;
         2:       return 11'd1024;
         3:       return 11'd2047;
         default: return DIM_W'($urandom_range(1, 64));
      endcase
   endfunction

   task automatic sender_pause();
      if (!quiet && sender_gap_odds != 0 && $urandom_range(1, sender_gap_odds) == 1) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // one tile entry over the req channel; valid stays high unless a gap follows
   task automatic send_tile(tile_entry_type t);
      req_if.valid           <= 1'b1;
      req_if.tile_id         <= t.id;
      req_if.flip_x          <= t.fx;
      req_if.flip_y          <= t.fy;
      req_if.prio            <= t.pr;
      req_if.obj_palette_one <= t.ob;
      req_if.pal_index       <= t.pal;
      req_if.last_tile       <= t.last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_tile(t);
      tiles_sent++;
      if (t.last) maps_closed++;
      sender_pause();
   endtask

   // wait until every predicted byte is out and the block has gone quiet
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_format(logic [FMT_W-1:0] code);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_FORMAT;
      csr_wdata <= {{(CSR_DATA_W - FMT_W){1'b0}}, code};
      @(posedge clock);
      csr_we      <= 1'b0;
      cur_format  = code;
      run_len     = 8'd0;
      run_byte    = 8'd0;
      header_done = 1'b0;
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_width  = w;
      cur_height = h;
      repeat (4) @(posedge clock);
   endtask

   // a map of len tiles; run formats draw ids from a small pool so that runs form
   task automatic send_map(int len, bit close);
      logic [TILE_ID_W-1:0] pool [4];
      logic [TILE_ID_W-1:0] id;
      bit                   runs;
      runs    = (cur_format == FMT_RLE_NIBBLE || cur_format == FMT_RLE_PAIR_00 ||
                 cur_format == FMT_RLE_PAIR_FF);
      pool[0] = TILE_ID_W'($urandom_range(0, 2047));
      pool[1] = pool[0] ^ 11'h100;
      pool[2] = TILE_ID_W'($urandom_range(0, 2047));
      pool[3] = TILE_ID_W'($urandom_range(0, 2047));
      id      = pool[0];
      for (int i = 0; i < len; i++) begin
         if (!runs) id = TILE_ID_W'($urandom_range(0, 2047));
         else if (i == 0 || $urandom_range(0, 2) == 0) id = pool[2'($urandom_range(0, 3))];
         send_tile(random_tile(id, close && i == len - 1));
      end
   endtask

   task automatic test_reset_defaults();
      send_tile(make_tile(11'h7FF, 1'b1, 1'b1, 1'b1, 1'b1, 5'h1F, 1'b0));
      send_tile(make_tile(11'h000, 1'b0, 1'b0, 1'b0, 1'b0, 5'd15, 1'b1));
   endtask

   task automatic test_every_format();
      logic [FMT_W-1:0] code;
      for (int f = 0; f < 16; f++) begin
         code = FMT_W'(f);
         write_format(code);
         if (code[0]) send_tile(make_tile(11'h7FF, 1'b1, 1'b1, 1'b1, 1'b1, 5'd15, 1'b1));
         else         send_tile(make_tile(11'h000, 1'b0, 1'b0, 1'b0, 1'b0, 5'h10, 1'b1));
      end
   endtask

   task automatic test_header_sizes();
      write_format(FMT_4BPP_HDR);
      write_size(11'd0, 11'd1024);
      send_tile(random_tile(TILE_ID_W'($urandom_range(0, 2047)), 1'b1));
      write_size(11'd2047, 11'd2047);
      send_tile(random_tile(TILE_ID_W'($urandom_range(0, 2047)), 1'b0));
      send_tile(random_tile(TILE_ID_W'($urandom_range(0, 2047)), 1'b1));
      write_format(FMT_8BPP_HDR);
      write_size(11'd1, 11'd1);
      send_tile(random_tile(TILE_ID_W'($urandom_range(0, 2047)), 1'b1));
   endtask

   task automatic test_nibble_run_limit();
      write_format(FMT_RLE_NIBBLE);
      repeat (16) send_tile(random_tile(11'h2A5, 1'b0));
      // same low byte, different high bits: still the same run
      send_tile(random_tile(11'h0A5, 1'b1));
   endtask

   task automatic test_writes_mid_run();
      write_format(FMT_RLE_PAIR_FF);
      repeat (3) send_tile(random_tile(11'h011, 1'b0));
      write_format(FMT_RLE_PAIR_FF);
      send_tile(random_tile(11'h011, 1'b1));
      write_format(FMT_RLE_PAIR_00);
      repeat (2) send_tile(random_tile(11'h4EE, 1'b0));
      write_size(11'd32, 11'd32);
      send_tile(random_tile(11'h4EE, 1'b1));
   endtask

   task automatic test_drain_pause();
      write_format(FMT_8BPP_HDR);
      write_size(11'd3, 11'd2);
      send_map(3, 1'b0);
      drain_results();
      send_map(3, 1'b1);
   endtask

   task automatic test_random_maps();
      int               counted;
      int               len;
      logic [FMT_W-1:0] code;
      counted = 0;
      while (counted < 30) begin
         if ($urandom_range(0, 9) < 4)
            code = ($urandom_range(0, 2) == 0) ? FMT_RLE_NIBBLE :
                   ($urandom_range(0, 1) == 0) ? FMT_RLE_PAIR_00 : FMT_RLE_PAIR_FF;
         else
            code = FMT_W'($urandom_range(0, 15));
         if (counted == 0 || $urandom_range(0, 3) != 0) write_format(code);
         if ($urandom_range(0, 2) == 0) write_size(pick_dim(), pick_dim());
         sender_gap_odds = $urandom_range(0, 1) ? 0 : $urandom_range(2, 5);
         len = (cur_format == FMT_RLE_NIBBLE || cur_format == FMT_RLE_PAIR_00 ||
                cur_format == FMT_RLE_PAIR_FF) ? $urandom_range(1, 16) : $urandom_range(1, 6);
         // now and then an unfinished map, continued by the next map or cut off by a format write
         send_map(len, $urandom_range(0, 7) != 0);
         if (cur_format != FMT_UNUSED) counted += len;
      end
   endtask

   task automatic test_back_to_back();
      quiet = 1'b1;
      write_format(FMT_ATTR9);
      send_map(8, 1'b1);
      write_format(FMT_RLE_PAIR_FF);
      send_map(10, 1'b1);
      write_format(FMT_4BPP_HDR);
      send_map(6, 1'b1);
   endtask

   initial begin
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_FORMAT;
      csr_wdata              = '0;
      req_if.valid           = 1'b0;
      req_if.tile_id         = '0;
      req_if.flip_x          = 1'b0;
      req_if.flip_y          = 1'b0;
      req_if.prio            = 1'b0;
      req_if.obj_palette_one = 1'b0;
      req_if.pal_index       = '0;
      req_if.last_tile       = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_every_format();
      test_header_sizes();
      test_nibble_run_limit();
      test_writes_mid_run();
      test_drain_pause();
      test_random_maps();
      test_back_to_back();

      drain_results();
      $display("covered %0d tiles in %0d closed maps over all format codes, header sizes,",
               tiles_sent, maps_closed);
      $display("the nibble run limit and mid-map register writes; %0d bytes compared, %0d mismatches",
               bytes_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
